@@ hw/rtl/dde_pkg.sv @@
package dde_pkg;

    // sample and twiddle word width, fraction bits of the twiddles
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 15;

    // product, term and accumulator widths of the complex mac
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int TERM_W      = PROD_W + 1;
    localparam int ACC_W       = 40;

    // result fields
    localparam int BIN_W       = 6;
    localparam int OUT_W       = 25;

    // stream data widths
    localparam int IN_TDATA_W  = 2 * SAMPLE_W;
    localparam int OUT_TDATA_W = BIN_W + 2 * OUT_W;

    // complex word, real part in the low bits
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] im;
        logic signed [SAMPLE_W-1:0] re;
    } t_cplx;

    // control from the sequencer to the mac unit
    typedef struct packed {
        logic valid;
        logic clear;
    } t_mac_ctl;

endpackage

@@ hw/rtl/dde_twiddle_rom.sv @@
module dde_twiddle_rom import dde_pkg::*; #(
    parameter int FRAME_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic [$clog2(FRAME_SIZE)-1:0] i_addr,
    output t_cplx                         o_tw     // re = cos, im = sin
);

    localparam logic [63:0] PI4_Q30 = 64'd843314857;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // q30 to q15 with round half up, clamp to [0, 32767]
    function automatic logic signed [SAMPLE_W-1:0] round_q15(input logic signed [63:0] v);
        logic signed [63:0] vv;
        logic signed [63:0] r;
        vv = (v < 0) ? 64'sd0 : v;
        r  = (vv + 64'sd16384) >>> FRAC_W;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // cos and sin of angle m*2*pi/N through octant fold and taylor series
    function automatic t_cplx tw_entry(input int m);
        logic [63:0]        u;
        logic [63:0]        o;
        logic [63:0]        a;
        logic [63:0]        g;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        logic signed [63:0] sv;
        logic signed [63:0] cv;
        logic signed [63:0] c0;
        logic signed [63:0] s0;
        logic signed [63:0] cr;
        logic signed [63:0] sr;
        t_cplx              res;
        u = 64'(m) * 64'd8;
        o = (u / FRAME_SIZE) & 64'd7;
        a = u % FRAME_SIZE;
        g = o[0] ? (64'(FRAME_SIZE) - a) : a;
        x  = (g * PI4_Q30) / FRAME_SIZE;
        x2 = (x * x) >> 30;
        // sine series
        t  = x;
        ss = signed'(x);
        t  = ((t * x2) >> 30) / 64'd6;
        ss = ss - signed'(t);
        t  = ((t * x2) >> 30) / 64'd20;
        ss = ss + signed'(t);
        t  = ((t * x2) >> 30) / 64'd42;
        ss = ss - signed'(t);
        t  = ((t * x2) >> 30) / 64'd72;
        ss = ss + signed'(t);
        // cosine series
        t  = ONE_Q30;
        cs = signed'(ONE_Q30);
        t  = ((t * x2) >> 30) / 64'd2;
        cs = cs - signed'(t);
        t  = ((t * x2) >> 30) / 64'd12;
        cs = cs + signed'(t);
        t  = ((t * x2) >> 30) / 64'd30;
        cs = cs - signed'(t);
        t  = ((t * x2) >> 30) / 64'd56;
        cs = cs + signed'(t);
        t  = ((t * x2) >> 30) / 64'd90;
        cs = cs - signed'(t);
        sv = 64'(round_q15(ss));
        cv = 64'(round_q15(cs));
        // odd octants swap sine and cosine
        if (o[0]) begin
            c0 = sv;
            s0 = cv;
        end else begin
            c0 = cv;
            s0 = sv;
        end
        // quadrant rotation
        case (o[2:1])
            2'd0: begin
                cr = c0;
                sr = s0;
            end
            2'd1: begin
                cr = -s0;
                sr = c0;
            end
            2'd2: begin
                cr = -c0;
                sr = -s0;
            end
            default: begin
                cr = s0;
                sr = -c0;
            end
        endcase
        res.re = cr[SAMPLE_W-1:0];
        res.im = sr[SAMPLE_W-1:0];
        return res;
    endfunction

    t_cplx w_tab [FRAME_SIZE];
    t_cplx r_tw;

    // constant table, one entry per angle step
    for (genvar gi = 0; gi < FRAME_SIZE; gi++) begin : g_tab
        localparam t_cplx ENTRY = tw_entry(gi);
        assign w_tab[gi] = ENTRY;
    end

    // registered table read
    always_ff @(posedge i_clk) begin
        r_tw <= w_tab[i_addr];
    end

    assign o_tw = r_tw;

endmodule

@@ hw/rtl/dde_cmac.sv @@
module dde_cmac import dde_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  t_cplx                   i_x,
    input  t_cplx                   i_tw,
    output logic                    o_busy,
    output logic signed [ACC_W-1:0] o_acc_re,
    output logic signed [ACC_W-1:0] o_acc_im
);

    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_p_rc;
    logic signed [PROD_W-1:0] r_p_is;
    logic signed [PROD_W-1:0] r_p_ic;
    logic signed [PROD_W-1:0] r_p_rs;
    logic signed [TERM_W-1:0] r_sum_re;
    logic signed [TERM_W-1:0] r_sum_im;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    // four partial products
    always_ff @(posedge i_clk) begin
        r_p_rc <= i_x.re * i_tw.re;
        r_p_is <= i_x.im * i_tw.im;
        r_p_ic <= i_x.im * i_tw.re;
        r_p_rs <= i_x.re * i_tw.im;
    end

    // x * (c - j*s): real = xr*c + xi*s, imag = xi*c - xr*s
    always_ff @(posedge i_clk) begin
        r_sum_re <= TERM_W'(r_p_rc) + TERM_W'(r_p_is);
        r_sum_im <= TERM_W'(r_p_ic) - TERM_W'(r_p_rs);
    end

    // accumulate one term per cycle, cleared at bin start
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + ACC_W'(r_sum_re);
            r_acc_im <= r_acc_im + ACC_W'(r_sum_im);
        end
    end

    assign o_busy   = r_v1 | r_v2;
    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

@@ hw/rtl/direct_dft_engine.sv @@
// direct dft over a frame of FRAME_SIZE complex samples, one complex mac per cycle while a bin runs
// samples are taken one per cycle until the frame is full, then the input stalls
// each bin issues FRAME_SIZE mac terms, then drains the mac pipeline and loads the output register
// synchronous active-low reset clears the sequencer, sample count, mode and output valid
module direct_dft_engine import dde_pkg::*; #(
    parameter int FRAME_SIZE = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // sample_real, sample_imag
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // bin_index, bin_real, bin_imag
    output logic                   o_m_axis_tlast,   // last_bin
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata       // real_only_mode
);

    localparam int                IDX_W    = $clog2(FRAME_SIZE);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(FRAME_SIZE - 1);
    localparam logic [IDX_W:0]    N_W      = (IDX_W + 1)'(FRAME_SIZE);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic                     r_real_only;
    logic [IDX_W-1:0]         r_cnt;
    logic [IDX_W-1:0]         r_k;
    logic [IDX_W-1:0]         r_kk;
    logic                     r_mirror;
    logic [IDX_W-1:0]         r_n;
    logic [IDX_W-1:0]         r_m;
    logic                     r_issue_d;
    t_cplx                    r_store [FRAME_SIZE];
    t_cplx                    r_mem_q;
    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;
    logic                     r_out_last;

    logic                     w_s_acc;
    logic                     w_out_free;
    logic                     w_issue;
    logic                     w_start_run;
    logic [IDX_W-1:0]         w_k_start;
    logic                     w_mirror_start;
    logic [IDX_W-1:0]         w_kk_start;
    logic [IDX_W:0]           w_m_sum;
    logic [IDX_W-1:0]         w_m_next;
    t_cplx                    w_x;
    t_cplx                    w_tw;
    t_mac_ctl                 w_mac_ctl;
    logic                     w_mac_busy;
    logic signed [ACC_W-1:0]  w_acc_re;
    logic signed [ACC_W-1:0]  w_acc_im;
    logic signed [ACC_W-1:0]  w_re_sh;
    logic signed [ACC_W-1:0]  w_im_sh;
    logic signed [ACC_W-1:0]  w_im_out;

    // handshakes
    assign o_s_axis_tready = (r_state == S_LOAD);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_issue         = (r_state == S_RUN);

    // a bin starts after the frame fills or after the previous bin is loaded out
    assign w_start_run = ((r_state == S_LOAD) && w_s_acc && (r_cnt == LAST_IDX))
                      || ((r_state == S_EMIT) && w_out_free && (r_k != LAST_IDX));

    // upper bins in real-only mode reuse the mirror bin and conjugate it
    assign w_k_start      = (r_state == S_LOAD) ? '0 : r_k + 1'b1;
    assign w_mirror_start = r_real_only && ({w_k_start, 1'b0} > N_W);
    assign w_kk_start     = w_mirror_start ? IDX_W'(N_W - {1'b0, w_k_start}) : w_k_start;

    // twiddle index (n*k) mod N by repeated add and wrap
    assign w_m_sum  = {1'b0, r_m} + {1'b0, r_kk};
    assign w_m_next = (w_m_sum >= N_W) ? IDX_W'(w_m_sum - N_W) : w_m_sum[IDX_W-1:0];

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_s_acc && (r_cnt == LAST_IDX)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_n == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_issue_d && !w_mac_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_k == LAST_IDX) ? S_LOAD : S_RUN;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_real_only <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_kk        <= '0;
            r_mirror    <= 1'b0;
            r_n         <= '0;
            r_m         <= '0;
            r_issue_d   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue_d <= w_issue;
            if (i_cfg_we) begin
                r_real_only <= i_cfg_wdata;
            end
            if (w_s_acc) begin
                r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
            end
            if (w_start_run) begin
                r_k      <= w_k_start;
                r_kk     <= w_kk_start;
                r_mirror <= w_mirror_start;
                r_n      <= '0;
                r_m      <= '0;
            end else if (w_issue) begin
                r_n <= r_n + 1'b1;
                r_m <= w_m_next;
            end
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample store, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_store[r_cnt] <= t_cplx'(i_s_axis_tdata);
        end
        r_mem_q <= r_store[r_n];
    end

    dde_twiddle_rom #(
        .FRAME_SIZE (FRAME_SIZE)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_m),
        .o_tw   (w_tw)
    );

    // imaginary input counts as zero in real-only mode
    always_comb begin
        w_x.re = r_mem_q.re;
        w_x.im = r_real_only ? '0 : r_mem_q.im;
    end

    assign w_mac_ctl.valid = r_issue_d;
    assign w_mac_ctl.clear = w_start_run;

    dde_cmac u_cmac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_x      (w_x),
        .i_tw     (w_tw),
        .o_busy   (w_mac_busy),
        .o_acc_re (w_acc_re),
        .o_acc_im (w_acc_im)
    );

    // floor scaling by 2^15, conjugate for mirrored bins
    assign w_re_sh  = w_acc_re >>> FRAC_W;
    assign w_im_sh  = w_acc_im >>> FRAC_W;
    assign w_im_out = r_mirror ? -w_im_sh : w_im_sh;

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out_data <= {w_im_out[OUT_W-1:0], w_re_sh[OUT_W-1:0], BIN_W'(r_k)};
            r_out_last <= (r_k == LAST_IDX);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

@@ test/tb_direct_dft_engine.sv @@
module tb_direct_dft_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import dde_pkg::*;

    localparam int N            = 64;
    localparam int WATCH_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int CFG_SETTLE   = 8;

    localparam bit MODE_COMPLEX   = 1'b0;
    localparam bit MODE_REAL_ONLY = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    // pi/4 and one in q2.30
    localparam longint unsigned PI4_Q30 = 64'd843314857;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    // one frequency bin as it leaves the block
    typedef struct packed {
        logic [BIN_W-1:0] bin_k;
        logic [OUT_W-1:0] bin_re;
        logic [OUT_W-1:0] bin_im;
        logic             bin_last;
    } t_dft_bin;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;    // sample_real, sample_imag
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;    // bin_index, bin_real, bin_imag
    logic                   o_m_axis_tlast;    // last_bin
    logic                   i_cfg_we;
    logic                   i_cfg_wdata;       // real_only_mode

    // predictor state
    longint   tw_cos [N];
    longint   tw_sin [N];
    int       frame_re [N];
    int       frame_im [N];
    int       frame_fill = 0;
    bit       mode_model = MODE_COMPLEX;
    t_dft_bin expected_bins [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int ready_hold   = 0;
    bit no_gaps      = 1'b0;
    bit sample_hi    = 1'b0;

    direct_dft_engine #(
        .FRAME_SIZE (N)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // q2.30 to q15 with rounding, negative clamps to zero
    function automatic longint round_q15(input longint v);
        longint r;
        r = (v < 0) ? 64'sd0 : (v + 64'sd16384) / 64'sd32768;
        return (r > 64'sd32767) ? 64'sd32767 : r;
    endfunction

    // taylor series sin/cos of an angle in the first octant
    function automatic void octant_trig(input longint unsigned g, output longint s_q15,
                                        output longint c_q15);
        longint unsigned x, x2, t;
        longint          ss, cs;
        x  = (g * PI4_Q30) / N;
        x2 = (x * x) >> 30;
        ss = longint'(x);
        cs = longint'(ONE_Q30);
        t  = x;
        for (int j = 1; j <= 4; j++) begin
            t  = ((t * x2) >> 30) / longint'((2 * j) * (2 * j + 1));
            ss = (j % 2) ? ss - longint'(t) : ss + longint'(t);
        end
        t = ONE_Q30;
        for (int j = 1; j <= 5; j++) begin
            t  = ((t * x2) >> 30) / longint'((2 * j - 1) * (2 * j));
            cs = (j % 2) ? cs - longint'(t) : cs + longint'(t);
        end
        s_q15 = round_q15(ss);
        c_q15 = round_q15(cs);
    endfunction

    // full-width complex sum for bin k, then floor shift by 15
    function automatic void predict_bin(input int k, output longint re, output longint im);
        longint sr, si, xr, xi;
        int     m;
        sr = 0;
        si = 0;
        for (int n = 0; n < N; n++) begin
            m  = (n * k) % N;
            xr = frame_re[n];
            xi = (mode_model == MODE_REAL_ONLY) ? 0 : frame_im[n];
            sr += xr * tw_cos[m] + xi * tw_sin[m];
            si += xi * tw_cos[m] - xr * tw_sin[m];
        end
        re = sr >>> 15;
        im = si >>> 15;
    endfunction

    // store one accepted sample, queue all bins when the frame is full
    function automatic void take_sample(input int re, input int im);
        t_dft_bin b;
        longint   br, bi;
        frame_re[frame_fill] = re;
        frame_im[frame_fill] = im;
        if (frame_fill < N - 1) begin
            frame_fill++;
            return;
        end
        frame_fill = 0;
        for (int k = 0; k < N; k++) begin
            if (mode_model == MODE_REAL_ONLY && 2 * k > N) begin
                // upper bins mirror as conjugates
                predict_bin(N - k, br, bi);
                bi = -bi;
            end else begin
                predict_bin(k, br, bi);
            end
            b.bin_k    = BIN_W'(k);
            b.bin_re   = br[OUT_W-1:0];
            b.bin_im   = bi[OUT_W-1:0];
            b.bin_last = (k == N - 1);
            expected_bins.push_back(b);
        end
    endfunction

    // one sample transaction, random gap before it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
                               input logic signed [SAMPLE_W-1:0] im, input bit drop_after);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            if (sample_hi) begin
                i_s_axis_tvalid <= 1'b0;
                sample_hi = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {im, re};
        sample_hi = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        take_sample(int'(re), int'(im));
        if (drop_after) begin
            i_s_axis_tvalid <= 1'b0;
            sample_hi = 1'b0;
        end
    endtask

    // mode write once every queued bin has come out
    task automatic write_mode(input bit mode);
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        mode_model = mode;
        i_cfg_we <= 1'b0;
    endtask

    // complex mode from reset, full-scale patterns on both parts
    task automatic test_complex_extremes();
        logic signed [SAMPLE_W-1:0] re, im;
        for (int n = 0; n < N; n++) begin
            case (n % 8)
                0: begin re = S_MAX; im = S_MIN; end
                1: begin re = S_MIN; im = S_MAX; end
                2: begin re = S_MAX; im = S_MAX; end
                3: begin re = S_MIN; im = S_MIN; end
                4: begin re = 16'sd0; im = 16'sd0; end
                5: begin re = -16'sd1; im = 16'sd1; end
                6: begin re = S_MAX; im = 16'sd0; end
                default: begin re = 16'sd0; im = S_MIN; end
            endcase
            send_sample(re, im, n == N - 1);
        end
    endtask

    // real-only: imaginary input ignored, upper bins conjugated
    task automatic test_real_only_mirror();
        logic signed [SAMPLE_W-1:0] re, im;
        write_mode(MODE_REAL_ONLY);
        for (int n = 0; n < N; n++) begin
            if (n == 0)
                re = S_MAX;
            else if (n == 3)
                re = S_MIN;
            else
                re = SAMPLE_W'($urandom_range(0, 64) - 32);
            im = (n % 2) ? S_MIN : S_MAX;
            send_sample(re, im, n == N - 1);
        end
    endtask

    // random frame, samples back to back but for the mode switch: random mode flipped mid-frame, completion mode rules
    task automatic test_random_frames();
        logic signed [SAMPLE_W-1:0] re, im;
        int switch_at, pick;
        no_gaps = 1'b1;
        write_mode(1'($urandom_range(0, 1)));
        switch_at = $urandom_range(1, N - 1);
        for (int n = 0; n < N; n++) begin
            if (n == switch_at)
                write_mode(~mode_model);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                re = SAMPLE_W'($urandom());
                im = SAMPLE_W'($urandom());
            end else if (pick < 8) begin
                re = SAMPLE_W'($urandom_range(0, 8) - 4);
                im = SAMPLE_W'($urandom_range(0, 8) - 4);
            end else begin
                case ($urandom_range(0, 3))
                    0: re = S_MAX;
                    1: re = S_MIN;
                    2: re = 16'sd0;
                    default: re = -16'sd1;
                endcase
                im = $urandom_range(0, 1) ? S_MAX : S_MIN;
            end
            send_sample(re, im, n + 1 == switch_at || n == N - 1);
        end
        no_gaps = 1'b0;
    endtask

    // result side: check each bin transaction, then draw a stall for the next one
    always @(posedge i_clk) begin
        t_dft_bin got, want;
        int       stall;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got.bin_k    = o_m_axis_tdata[BIN_W-1:0];
            got.bin_re   = o_m_axis_tdata[BIN_W +: OUT_W];
            got.bin_im   = o_m_axis_tdata[BIN_W + OUT_W +: OUT_W];
            got.bin_last = o_m_axis_tlast;
            if (expected_bins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected bin transaction: k=%0d re=%0d im=%0d last=%0b",
                             got.bin_k, $signed(got.bin_re), $signed(got.bin_im),
                             got.bin_last);
            end else begin
                want = expected_bins.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"bin mismatch: expected k=%0d re=%0d im=%0d last=%0b,",
                                  " got k=%0d re=%0d im=%0d last=%0b"},
                                 want.bin_k, $signed(want.bin_re), $signed(want.bin_im),
                                 want.bin_last, got.bin_k, $signed(got.bin_re),
                                 $signed(got.bin_im), got.bin_last);
                end
            end
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                ready_hold      <= stall;
            end
        end else if (!i_m_axis_tready && (o_m_axis_tvalid || ready_hold == 0)) begin
            // stall only counts cycles with a bin waiting
            if (ready_hold <= 1)
                i_m_axis_tready <= 1'b1;
            else
                ready_hold <= ready_hold - 1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCH_LIMIT) begin
            $display("[direct_dft_engine] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        longint unsigned u, oct, a;
        longint          sv, cv, c0, s0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= MODE_COMPLEX;

        // q15 twiddle table, octant reduction then quadrant mapping
        for (int m = 0; m < N; m++) begin
            u   = 8 * m;
            oct = (u / N) % 8;
            a   = u % N;
            if (oct % 2) begin
                octant_trig(N - a, sv, cv);
                c0 = sv;
                s0 = cv;
            end else begin
                octant_trig(a, sv, cv);
                c0 = cv;
                s0 = sv;
            end
            case (oct / 2)
                0: begin tw_cos[m] = c0;  tw_sin[m] = s0;  end
                1: begin tw_cos[m] = -s0; tw_sin[m] = c0;  end
                2: begin tw_cos[m] = -c0; tw_sin[m] = -s0; end
                default: begin tw_cos[m] = s0; tw_sin[m] = -c0; end
            endcase
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_complex_extremes();
        test_real_only_mirror();
        test_random_frames();

        // drain outstanding bins, then let the pipeline settle
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("[direct_dft_engine] OK");
        else
            $display("[direct_dft_engine] ERROR");
        $finish;
    end

endmodule
